[sv/rcpbd_pkg.sv]
`default_nettype none
package rcpbd_pkg;

   localparam int PULSE_W = 12;
   localparam int MV_W    = 15;
   localparam int DUTY_W  = 8;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 15;

   // number of battery sample fields on the input item
   localparam int SAMPLE_INPUTS = 5;

   localparam logic [DUTY_W-1:0] FULL_POWER_NORMAL = 8'd255;
   localparam logic [DUTY_W-1:0] FULL_POWER_DEAD   = 8'd48;

   typedef enum logic [CSR_AW-1:0] {
      CSR_LOW_THRESHOLD  = 3'd0,
      CSR_HIGH_THRESHOLD = 3'd1,
      CSR_MIN_PULSE      = 3'd2,
      CSR_MAX_PULSE      = 3'd3,
      CSR_LOW_SPAN       = 3'd4,
      CSR_HIGH_SPAN      = 3'd5,
      CSR_CUTOFF_MV      = 3'd6,
      CSR_SLEW_ENABLE    = 3'd7
   } csr_addr_type;

   localparam logic [PULSE_W-1:0] RST_LOW_THRESHOLD  = 12'd1450;
   localparam logic [PULSE_W-1:0] RST_HIGH_THRESHOLD = 12'd1550;
   localparam logic [PULSE_W-1:0] RST_MIN_PULSE      = 12'd1000;
   localparam logic [PULSE_W-1:0] RST_MAX_PULSE      = 12'd2000;
   localparam logic [PULSE_W-1:0] RST_LOW_SPAN       = 12'd450;
   localparam logic [PULSE_W-1:0] RST_HIGH_SPAN      = 12'd450;
   localparam logic [MV_W-1:0]    RST_CUTOFF_MV      = 15'd3400;

endpackage
`default_nettype wire

[sv/rcpbd_ifs.sv]
`default_nettype none
interface rcpbd_req_if;
   logic                           valid;
   logic                           ready;
   logic [rcpbd_pkg::PULSE_W-1:0]  pulse_width;
   logic [rcpbd_pkg::MV_W-1:0]     battery_mv_a;
   logic [rcpbd_pkg::MV_W-1:0]     battery_mv_b;
   logic [rcpbd_pkg::MV_W-1:0]     battery_mv_c;
   logic [rcpbd_pkg::MV_W-1:0]     battery_mv_d;
   logic [rcpbd_pkg::MV_W-1:0]     battery_mv_e;

   modport source (output valid, pulse_width, battery_mv_a, battery_mv_b, battery_mv_c,
                   battery_mv_d, battery_mv_e, input ready);
   modport sink   (input valid, pulse_width, battery_mv_a, battery_mv_b, battery_mv_c,
                   battery_mv_d, battery_mv_e, output ready);
endinterface

interface rcpbd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rcpbd_pkg::DUTY_W-1:0]  drive_duty;
   logic                          reverse_relay;
   logic                          neutral_led;
   logic                          limit_led;
   logic                          batt_flat;
   logic                          outputs_held;

   modport source (output valid, drive_duty, reverse_relay, neutral_led, limit_led,
                   batt_flat, outputs_held, input ready);
   modport sink   (input valid, drive_duty, reverse_relay, neutral_led, limit_led,
                   batt_flat, outputs_held, output ready);
endinterface

interface rcpbd_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rcpbd_pkg::CSR_AW-1:0]  addr;
   logic [rcpbd_pkg::CSR_DW-1:0]  wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface
`default_nettype wire

[sv/rc_pulse_to_bidirectional_drive_top.sv]
// RC pulse to bidirectional drive mapping.
// req_ch carries one item: a measured pulse width and five battery samples (mV).
// rsp_ch returns exactly one item per request: duty, relay, LEDs, dead flag and
// a flag telling that a reversal snap left the drive outputs as they were.
// csr_ch writes the eight control registers; it is always ready and must only be
// used while no item is in flight.
// An accepted request passes through the track, evaluate and finish states when no division
// is needed (reversal snap, deadband, zero span or saturation); otherwise the long path
// adds a multiply state and eight steps of a shared restoring subtract-and-shift divider.
// req_ch.ready is high only while the sequencer is idle, so a new item is taken only
// after the previous one has left the sequencer for the output register.
// The result sits in an output register; the next item is accepted while it
// waits, and a stalled receiver holds the sequencer in its final state until
// rsp_ch.ready returns.
// Reset clears the sticky dead flag, the drive registers and the LEDs, sets the
// target pulse to neutral and loads the control registers with their defaults.
`default_nettype none
module rc_pulse_to_bidirectional_drive_top #(
   parameter int unsigned NEUTRAL_PULSE    = 1500,
   parameter int unsigned LOW_SAMPLE_COUNT = 5
) (
   input  wire              clock,
   input  wire              reset,
   rcpbd_req_if.sink        req_ch,
   rcpbd_rsp_if.source      rsp_ch,
   rcpbd_csr_if.sink        csr_ch
);

   localparam int LowCnt = (LOW_SAMPLE_COUNT > rcpbd_pkg::SAMPLE_INPUTS) ?
                           rcpbd_pkg::SAMPLE_INPUTS : int'(LOW_SAMPLE_COUNT);
   localparam logic [rcpbd_pkg::PULSE_W-1:0] Neutral = rcpbd_pkg::PULSE_W'(NEUTRAL_PULSE);
   localparam int PW = rcpbd_pkg::PULSE_W;
   localparam int DW = rcpbd_pkg::DUTY_W;
   localparam int MW = rcpbd_pkg::MV_W;
   localparam int ProdW = PW + DW;

   typedef enum logic [2:0] {
      ST_IDLE, ST_TRACK, ST_EVAL, ST_MUL, ST_DIV, ST_FINISH
   } state_type;

   state_type        state_ff, state_in;

   logic [PW-1:0]    low_thr_ff, low_thr_in;
   logic [PW-1:0]    high_thr_ff, high_thr_in;
   logic [PW-1:0]    min_pulse_ff, min_pulse_in;
   logic [PW-1:0]    max_pulse_ff, max_pulse_in;
   logic [PW-1:0]    low_span_ff, low_span_in;
   logic [PW-1:0]    high_span_ff, high_span_in;
   logic [MW-1:0]    cutoff_ff, cutoff_in;
   logic             slew_ff, slew_in;

   logic [PW-1:0]    pulse_ff, pulse_in;
   logic [PW-1:0]    target_ff, target_in;
   logic             dead_ff, dead_in;
   logic             held_ff, held_in;
   logic [DW-1:0]    duty_ff, duty_in;
   logic             relay_ff, relay_in;
   logic             neut_ff, neut_in;
   logic             lim_ff, lim_in;

   logic [PW-1:0]    dist_ff, dist_in;
   logic [DW-1:0]    fp_ff, fp_in;
   logic [PW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    low_ff, low_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [2:0]       step_ff, step_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]    o_duty_ff, o_duty_in;
   logic             o_relay_ff, o_relay_in;
   logic             o_neut_ff, o_neut_in;
   logic             o_lim_ff, o_lim_in;
   logic             o_dead_ff, o_dead_in;
   logic             o_held_ff, o_held_in;

   logic [MW-1:0]    samp_all [rcpbd_pkg::SAMPLE_INPUTS];
   logic             low_hit;
   logic             req_fire;
   logic             csr_fire;
   logic [PW-1:0]    span_sel;
   logic [ProdW-1:0] prod;
   logic [PW+1:0]    trial;

   assign samp_all[0] = req_ch.battery_mv_a;
   assign samp_all[1] = req_ch.battery_mv_b;
   assign samp_all[2] = req_ch.battery_mv_c;
   assign samp_all[3] = req_ch.battery_mv_d;
   assign samp_all[4] = req_ch.battery_mv_e;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_fire     = csr_ch.valid;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.drive_duty    = o_duty_ff;
   assign rsp_ch.reverse_relay = o_relay_ff;
   assign rsp_ch.neutral_led   = o_neut_ff;
   assign rsp_ch.limit_led     = o_lim_ff;
   assign rsp_ch.batt_flat     = o_dead_ff;
   assign rsp_ch.outputs_held  = o_held_ff;

   // all of the first samples low, independent compares
   always_comb begin
      low_hit = (LowCnt > 0);
      for (int i = 0; i < LowCnt; i++) begin
         if (!(samp_all[i] < cutoff_ff)) begin
            low_hit = 1'b0;
         end
      end
   end

   assign span_sel = relay_ff ? low_span_ff : high_span_ff;
   assign prod     = ProdW'(dist_ff) * ProdW'(fp_ff);
   assign trial    = {1'b0, rem_ff, low_ff[DW-1]} - {2'b00, span_sel};

   always_comb begin
      low_thr_in   = low_thr_ff;
      high_thr_in  = high_thr_ff;
      min_pulse_in = min_pulse_ff;
      max_pulse_in = max_pulse_ff;
      low_span_in  = low_span_ff;
      high_span_in = high_span_ff;
      cutoff_in    = cutoff_ff;
      slew_in      = slew_ff;
      if (csr_fire) begin
         case (rcpbd_pkg::csr_addr_type'(csr_ch.addr))
            rcpbd_pkg::CSR_LOW_THRESHOLD:  low_thr_in   = csr_ch.wdata[PW-1:0];
            rcpbd_pkg::CSR_HIGH_THRESHOLD: high_thr_in  = csr_ch.wdata[PW-1:0];
            rcpbd_pkg::CSR_MIN_PULSE:      min_pulse_in = csr_ch.wdata[PW-1:0];
            rcpbd_pkg::CSR_MAX_PULSE:      max_pulse_in = csr_ch.wdata[PW-1:0];
            rcpbd_pkg::CSR_LOW_SPAN:       low_span_in  = csr_ch.wdata[PW-1:0];
            rcpbd_pkg::CSR_HIGH_SPAN:      high_span_in = csr_ch.wdata[PW-1:0];
            rcpbd_pkg::CSR_CUTOFF_MV:      cutoff_in    = csr_ch.wdata[MW-1:0];
            rcpbd_pkg::CSR_SLEW_ENABLE:    slew_in      = csr_ch.wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      pulse_in     = pulse_ff;
      target_in    = target_ff;
      dead_in      = dead_ff;
      held_in      = held_ff;
      duty_in      = duty_ff;
      relay_in     = relay_ff;
      neut_in      = neut_ff;
      lim_in       = lim_ff;
      dist_in      = dist_ff;
      fp_in        = fp_ff;
      rem_in       = rem_ff;
      low_in       = low_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      o_duty_in    = o_duty_ff;
      o_relay_in   = o_relay_ff;
      o_neut_in    = o_neut_ff;
      o_lim_in     = o_lim_ff;
      o_dead_in    = o_dead_ff;
      o_held_in    = o_held_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pulse_in = req_ch.pulse_width;
               dead_in  = dead_ff | low_hit;
               state_in = ST_TRACK;
            end
         end
         ST_TRACK: begin
            held_in = 1'b0;
            if (slew_ff) begin
               if ((pulse_ff <= low_thr_ff && target_ff > Neutral) ||
                   (pulse_ff >= high_thr_ff && target_ff < Neutral)) begin
                  target_in = Neutral;
                  held_in   = 1'b1;
               end else if (pulse_ff > target_ff) begin
                  target_in = target_ff + 1'b1;
               end else if (pulse_ff < target_ff) begin
                  target_in = target_ff - 1'b1;
               end
            end else begin
               target_in = pulse_ff;
            end
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            fp_in    = dead_ff ? rcpbd_pkg::FULL_POWER_DEAD : rcpbd_pkg::FULL_POWER_NORMAL;
            state_in = ST_FINISH;
            if (!held_ff) begin
               if (target_ff > low_thr_ff && target_ff < high_thr_ff) begin
                  duty_in = '0;
                  neut_in = 1'b1;
                  lim_in  = 1'b0;
               end else begin
                  neut_in = 1'b0;
                  lim_in  = (target_ff <= min_pulse_ff) || (target_ff >= max_pulse_ff);
                  if (target_ff >= high_thr_ff) begin
                     relay_in = 1'b0;
                     dist_in  = target_ff - high_thr_ff;
                     if (high_span_ff == '0 || (target_ff - high_thr_ff) >= high_span_ff) begin
                        duty_in = fp_in;
                     end else begin
                        state_in = ST_MUL;
                     end
                  end else begin
                     relay_in = 1'b1;
                     dist_in  = low_thr_ff - target_ff;
                     if (low_span_ff == '0 || (low_thr_ff - target_ff) >= low_span_ff) begin
                        duty_in = fp_in;
                     end else begin
                        state_in = ST_MUL;
                     end
                  end
               end
            end
         end
         ST_MUL: begin
            // dist < span, so the top of the product is already below span
            rem_in   = prod[ProdW-1:DW];
            low_in   = prod[DW-1:0];
            quo_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!trial[PW+1]) begin
               rem_in = trial[PW-1:0];
            end else begin
               rem_in = {rem_ff[PW-2:0], low_ff[DW-1]};
            end
            low_in  = {low_ff[DW-2:0], 1'b0};
            quo_in  = {quo_ff[DW-2:0], !trial[PW+1]};
            step_in = step_ff + 1'b1;
            if (step_ff == 3'd7) begin
               duty_in  = quo_in;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               o_duty_in    = duty_ff;
               o_relay_in   = relay_ff;
               o_neut_in    = neut_ff;
               o_lim_in     = lim_ff;
               o_dead_in    = dead_ff;
               o_held_in    = held_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         low_thr_ff   <= rcpbd_pkg::RST_LOW_THRESHOLD;
         high_thr_ff  <= rcpbd_pkg::RST_HIGH_THRESHOLD;
         min_pulse_ff <= rcpbd_pkg::RST_MIN_PULSE;
         max_pulse_ff <= rcpbd_pkg::RST_MAX_PULSE;
         low_span_ff  <= rcpbd_pkg::RST_LOW_SPAN;
         high_span_ff <= rcpbd_pkg::RST_HIGH_SPAN;
         cutoff_ff    <= rcpbd_pkg::RST_CUTOFF_MV;
         slew_ff      <= 1'b1;
         target_ff    <= Neutral;
         dead_ff      <= 1'b0;
         held_ff      <= 1'b0;
         duty_ff      <= '0;
         relay_ff     <= 1'b0;
         neut_ff      <= 1'b0;
         lim_ff       <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_thr_ff   <= low_thr_in;
         high_thr_ff  <= high_thr_in;
         min_pulse_ff <= min_pulse_in;
         max_pulse_ff <= max_pulse_in;
         low_span_ff  <= low_span_in;
         high_span_ff <= high_span_in;
         cutoff_ff    <= cutoff_in;
         slew_ff      <= slew_in;
         target_ff    <= target_in;
         dead_ff      <= dead_in;
         held_ff      <= held_in;
         duty_ff      <= duty_in;
         relay_ff     <= relay_in;
         neut_ff      <= neut_in;
         lim_ff       <= lim_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pulse_ff   <= pulse_in;
      dist_ff    <= dist_in;
      fp_ff      <= fp_in;
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      quo_ff     <= quo_in;
      o_duty_ff  <= o_duty_in;
      o_relay_ff <= o_relay_in;
      o_neut_ff  <= o_neut_in;
      o_lim_ff   <= o_lim_in;
      o_dead_ff  <= o_dead_in;
      o_held_ff  <= o_held_in;
   end

endmodule
`default_nettype wire

[sv/rcpbd_checker.sv]
`default_nettype none
module rcpbd_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [7:0] rsp_duty,
   input wire       rsp_neutral,
   input wire       rsp_limit,
   input wire       rsp_dead,
   input wire       rsp_held
);

   // one item at a time: after an accept the block is busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on consecutive cycles");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duty))
      else $error("stalled item dropped or changed");

   a_neutral_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_neutral |-> rsp_duty == 8'd0 && !rsp_limit)
      else $error("neutral LED with drive or limit LED");

   a_dead_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dead |=> !rsp_valid || rsp_dead)
      else $error("battery dead flag cleared");

   a_dead_power: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dead && !rsp_held |-> rsp_duty <= rcpbd_pkg::FULL_POWER_DEAD)
      else $error("full power above reduced limit with dead battery");

endmodule

bind rc_pulse_to_bidirectional_drive_top rcpbd_checker u_rcpbd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_duty    (rsp_ch.drive_duty),
   .rsp_neutral (rsp_ch.neutral_led),
   .rsp_limit   (rsp_ch.limit_led),
   .rsp_dead    (rsp_ch.batt_flat),
   .rsp_held    (rsp_ch.outputs_held)
);
`default_nettype wire

[bench/testbench.sv]
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NEUTRAL_US      = 1500;
   localparam int unsigned LOW_RUN_NEEDED  = 5;
   localparam int unsigned LOW_RUN_CHECKED =
      (LOW_RUN_NEEDED > rcpbd_pkg::SAMPLE_INPUTS) ? rcpbd_pkg::SAMPLE_INPUTS : LOW_RUN_NEEDED;
   localparam int unsigned MV_MAX          = 21000;
   localparam int unsigned SETTLE_CYCLES   = 16;
   localparam int unsigned CYCLE_LIMIT     = 500000;
   localparam logic [rcpbd_pkg::PULSE_W-1:0] NEUTRAL_TGT = NEUTRAL_US[rcpbd_pkg::PULSE_W-1:0];

   typedef logic [rcpbd_pkg::SAMPLE_INPUTS-1:0][rcpbd_pkg::MV_W-1:0] mv_set_type;

   typedef struct packed {
      logic [rcpbd_pkg::PULSE_W-1:0] pulse;
      mv_set_type                    mv;
   } drive_item_type;

   typedef struct packed {
      logic [rcpbd_pkg::DUTY_W-1:0] duty;
      logic                         reverse;
      logic                         neutral;
      logic                         limit;
      logic                         dead;
      logic                         held;
   } drive_result_type;

   logic clock;
   logic reset;

   rcpbd_req_if req_if ();
   rcpbd_rsp_if rsp_if ();
   rcpbd_csr_if csr_if ();

   rc_pulse_to_bidirectional_drive_top #(
      .NEUTRAL_PULSE    (NEUTRAL_US),
      .LOW_SAMPLE_COUNT (LOW_RUN_NEEDED)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // control register copy
   logic [rcpbd_pkg::PULSE_W-1:0] low_thr  = rcpbd_pkg::RST_LOW_THRESHOLD;
   logic [rcpbd_pkg::PULSE_W-1:0] high_thr = rcpbd_pkg::RST_HIGH_THRESHOLD;
   logic [rcpbd_pkg::PULSE_W-1:0] min_p    = rcpbd_pkg::RST_MIN_PULSE;
   logic [rcpbd_pkg::PULSE_W-1:0] max_p    = rcpbd_pkg::RST_MAX_PULSE;
   logic [rcpbd_pkg::PULSE_W-1:0] low_sp   = rcpbd_pkg::RST_LOW_SPAN;
   logic [rcpbd_pkg::PULSE_W-1:0] high_sp  = rcpbd_pkg::RST_HIGH_SPAN;
   logic [rcpbd_pkg::MV_W-1:0]    cutoff   = rcpbd_pkg::RST_CUTOFF_MV;
   logic                          slew_on  = 1'b1;

   // drive state copy
   logic [rcpbd_pkg::PULSE_W-1:0] target    = NEUTRAL_TGT;
   logic                          dead_seen = 1'b0;
   logic [rcpbd_pkg::DUTY_W-1:0]  duty_q    = '0;
   logic                          relay_q   = 1'b0;
   logic                          neutral_q = 1'b0;
   logic                          limit_q   = 1'b0;

   drive_result_type drive_results_due[$];
   int unsigned      drive_mismatches = 0;
   int unsigned      cycle_count = 0;
   int unsigned      stall_request = 0;
   int unsigned      stall_left = 0;
   bit               quiet = 1'b0;
   bit               keep_battery = 1'b1;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.pulse_width = '0;
      req_if.battery_mv_a = '0;
      req_if.battery_mv_b = '0;
      req_if.battery_mv_c = '0;
      req_if.battery_mv_d = '0;
      req_if.battery_mv_e = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.addr = '0;
      csr_if.wdata = '0;
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic drive_result_type predict_drive(input drive_item_type it);
      int unsigned      run;
      int unsigned      fp;
      int unsigned      t;
      int unsigned      excess;
      int unsigned      span;
      int unsigned      scaled;
      bit               below;
      bit               snap;
      drive_result_type r;
      run = 0;
      below = 1'b1;
      // count the leading run of low samples only
      for (int i = 0; i < LOW_RUN_CHECKED; i++) begin
         below = below && (it.mv[i] < cutoff);
         if (below)
            run++;
      end
      if (LOW_RUN_CHECKED > 0 && run == LOW_RUN_CHECKED)
         dead_seen = 1'b1;

      snap = 1'b0;
      if (slew_on) begin
         if ((it.pulse <= low_thr && target > NEUTRAL_TGT) ||
             (it.pulse >= high_thr && target < NEUTRAL_TGT)) begin
            target = NEUTRAL_TGT;
            snap = 1'b1;
         end else if (it.pulse > target) begin
            target = target + 1'b1;
         end else if (it.pulse < target) begin
            target = target - 1'b1;
         end
      end else begin
         target = it.pulse;
      end

      if (!snap) begin
         t = 32'(target);
         if (t > 32'(low_thr) && t < 32'(high_thr)) begin
            duty_q = '0;
            neutral_q = 1'b1;
            limit_q = 1'b0;
         end else begin
            fp = dead_seen ? 32'(rcpbd_pkg::FULL_POWER_DEAD) : 32'(rcpbd_pkg::FULL_POWER_NORMAL);
            neutral_q = 1'b0;
            limit_q = (t <= 32'(min_p) || t >= 32'(max_p));
            // forward wins when the thresholds are crossed
            if (t >= 32'(high_thr)) begin
               relay_q = 1'b0;
               excess = t - 32'(high_thr);
               span = 32'(high_sp);
            end else begin
               relay_q = 1'b1;
               excess = 32'(low_thr) - t;
               span = 32'(low_sp);
            end
            scaled = (span == 0) ? fp : (excess * fp) / span;
            duty_q = (scaled > fp) ? fp[rcpbd_pkg::DUTY_W-1:0]
                                   : scaled[rcpbd_pkg::DUTY_W-1:0];
         end
      end
      r = '{duty_q, relay_q, neutral_q, limit_q, dead_seen, snap};
      return r;
   endfunction

   always @(posedge clock) begin
      drive_result_type got;
      drive_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.drive_duty, rsp_if.reverse_relay, rsp_if.neutral_led,
                 rsp_if.limit_led, rsp_if.batt_flat, rsp_if.outputs_held};
         if (drive_results_due.size() == 0) begin
            drive_mismatches++;
            if (drive_mismatches <= 10)
               $display("%0t: result with nothing outstanding: duty %0d", $realtime,
                        got.duty);
         end else begin
            want = drive_results_due.pop_front();
            if (got !== want) begin
               drive_mismatches++;
               if (drive_mismatches <= 10)
                  $display({"%0t: mismatch duty %0d/%0d relay %0b/%0b neutral %0b/%0b ",
                            "limit %0b/%0b dead %0b/%0b held %0b/%0b (expected/actual)"},
                           $realtime, want.duty, got.duty, want.reverse, got.reverse,
                           want.neutral, got.neutral, want.limit, got.limit,
                           want.dead, got.dead, want.held, got.held);
            end
         end
      end
   end

   // receiver: random idling plus a long hold-off when a test requests one
   always @(negedge clock) begin
      if (stall_request != 0) begin
         stall_left = stall_request;
         stall_request = 0;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= quiet || ($urandom_range(99) >= 6);
      end
   end

   function automatic drive_item_type make_item(input int unsigned p, input int unsigned a,
                                                input int unsigned b, input int unsigned c,
                                                input int unsigned d, input int unsigned e);
      drive_item_type it;
      it.pulse = p[rcpbd_pkg::PULSE_W-1:0];
      it.mv[0] = a[rcpbd_pkg::MV_W-1:0];
      it.mv[1] = b[rcpbd_pkg::MV_W-1:0];
      it.mv[2] = c[rcpbd_pkg::MV_W-1:0];
      it.mv[3] = d[rcpbd_pkg::MV_W-1:0];
      it.mv[4] = e[rcpbd_pkg::MV_W-1:0];
      return it;
   endfunction

   function automatic logic [rcpbd_pkg::PULSE_W-1:0] pick_pulse();
      int v;
      case ($urandom_range(0, 9))
         0:       v = $urandom_range(0, 4095);
         1:       v = $urandom_range(0, 1) ? 4095 : 0;
         2, 3:    v = int'(low_thr) + int'($urandom_range(0, 6)) - 3;
         4, 5:    v = int'(high_thr) + int'($urandom_range(0, 6)) - 3;
         6:       v = int'(min_p) + int'($urandom_range(0, 4)) - 2;
         7:       v = int'(max_p) + int'($urandom_range(0, 4)) - 2;
         default: v = int'(NEUTRAL_US) + int'($urandom_range(0, 120)) - 60;
      endcase
      if (v < 0)
         v = 0;
      if (v > 4095)
         v = 4095;
      return v[rcpbd_pkg::PULSE_W-1:0];
   endfunction

   function automatic mv_set_type pick_samples();
      mv_set_type s;
      int         v;
      bit         all_low;
      all_low = 1'b1;
      for (int i = 0; i < rcpbd_pkg::SAMPLE_INPUTS; i++) begin
         case ($urandom_range(0, 3))
            0: v = $urandom_range(0, MV_MAX);
            1: v = int'(cutoff) + int'($urandom_range(0, 3)) - 2;
            2: v = $urandom_range(0, cutoff);
            default: begin
               case ($urandom_range(0, 3))
                  0:       v = 0;
                  1:       v = MV_MAX;
                  2:       v = 16383;
                  default: v = 16384;
               endcase
            end
         endcase
         if (v < 0)
            v = 0;
         if (v > MV_MAX)
            v = MV_MAX;
         s[i] = v[rcpbd_pkg::MV_W-1:0];
         if (i < LOW_RUN_CHECKED && s[i] >= cutoff)
            all_low = 1'b0;
      end
      // keep the dead flag clear until the battery test wants it
      if (keep_battery && LOW_RUN_CHECKED > 0 && all_low)
         s[$urandom_range(0, LOW_RUN_CHECKED - 1)] = cutoff;
      return s;
   endfunction

   task automatic send_item(input drive_item_type it);
      int unsigned gap;
      gap = (!quiet && $urandom_range(99) < 6) ? $urandom_range(1, 16) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.pulse_width <= it.pulse;
      req_if.battery_mv_a <= it.mv[0];
      req_if.battery_mv_b <= it.mv[1];
      req_if.battery_mv_c <= it.mv[2];
      req_if.battery_mv_d <= it.mv[3];
      req_if.battery_mv_e <= it.mv[4];
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      drive_results_due.push_back(predict_drive(it));
   endtask

   // drop valid and wait for the block to finish every item in flight
   task automatic settle_block();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (drive_results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input rcpbd_pkg::csr_addr_type addr, input int unsigned value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.addr <= addr;
      csr_if.wdata <= value[rcpbd_pkg::CSR_DW-1:0];
      do @(posedge clock); while (!csr_if.ready);
      case (addr)
         rcpbd_pkg::CSR_LOW_THRESHOLD:  low_thr = value[rcpbd_pkg::PULSE_W-1:0];
         rcpbd_pkg::CSR_HIGH_THRESHOLD: high_thr = value[rcpbd_pkg::PULSE_W-1:0];
         rcpbd_pkg::CSR_MIN_PULSE:      min_p = value[rcpbd_pkg::PULSE_W-1:0];
         rcpbd_pkg::CSR_MAX_PULSE:      max_p = value[rcpbd_pkg::PULSE_W-1:0];
         rcpbd_pkg::CSR_LOW_SPAN:       low_sp = value[rcpbd_pkg::PULSE_W-1:0];
         rcpbd_pkg::CSR_HIGH_SPAN:      high_sp = value[rcpbd_pkg::PULSE_W-1:0];
         rcpbd_pkg::CSR_CUTOFF_MV:      cutoff = value[rcpbd_pkg::MV_W-1:0];
         rcpbd_pkg::CSR_SLEW_ENABLE:    slew_on = value[0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input int unsigned lo, input int unsigned hi,
                                 input int unsigned mn, input int unsigned mx,
                                 input int unsigned lsp, input int unsigned hsp,
                                 input int unsigned cut, input int unsigned slew);
      settle_block();
      write_reg(rcpbd_pkg::CSR_LOW_THRESHOLD, lo);
      write_reg(rcpbd_pkg::CSR_HIGH_THRESHOLD, hi);
      write_reg(rcpbd_pkg::CSR_MIN_PULSE, mn);
      write_reg(rcpbd_pkg::CSR_MAX_PULSE, mx);
      write_reg(rcpbd_pkg::CSR_LOW_SPAN, lsp);
      write_reg(rcpbd_pkg::CSR_HIGH_SPAN, hsp);
      write_reg(rcpbd_pkg::CSR_CUTOFF_MV, cut);
      write_reg(rcpbd_pkg::CSR_SLEW_ENABLE, slew);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic apply_defaults(input int unsigned slew);
      apply_settings(32'(rcpbd_pkg::RST_LOW_THRESHOLD), 32'(rcpbd_pkg::RST_HIGH_THRESHOLD),
                     32'(rcpbd_pkg::RST_MIN_PULSE), 32'(rcpbd_pkg::RST_MAX_PULSE),
                     32'(rcpbd_pkg::RST_LOW_SPAN), 32'(rcpbd_pkg::RST_HIGH_SPAN),
                     32'(rcpbd_pkg::RST_CUTOFF_MV), slew);
   endtask

   task automatic random_settings(input bit slew);
      int unsigned lo;
      int unsigned hi;
      int unsigned tmp;
      int unsigned mn;
      int unsigned mx;
      int unsigned lsp;
      int unsigned hsp;
      if (slew) begin
         // keep the thresholds close to neutral so that ramps reach them
         lo = NEUTRAL_US - $urandom_range(0, 40);
         hi = NEUTRAL_US + $urandom_range(0, 40);
         if ($urandom_range(0, 7) == 0) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
         end
         mn = lo - $urandom_range(0, 30);
         mx = hi + $urandom_range(0, 30);
         lsp = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
         hsp = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      end else begin
         lo = $urandom_range(0, 4095);
         hi = $urandom_range(0, 4095);
         mn = $urandom_range(0, 4095);
         mx = $urandom_range(0, 4095);
         lsp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 600);
         hsp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 600);
      end
      apply_settings(lo, hi, mn, mx, lsp, hsp, $urandom_range(0, MV_MAX), 32'(slew));
   endtask

   task automatic run_items(input int unsigned n);
      drive_item_type                it;
      logic [rcpbd_pkg::PULSE_W-1:0] hold_pulse;
      int unsigned                   run;
      run = 0;
      hold_pulse = NEUTRAL_TGT;
      for (int k = 0; k < n; k++) begin
         if (slew_on) begin
            // mostly hold one request long enough for the target to ramp, with some noise
            if (run == 0) begin
               hold_pulse = pick_pulse();
               run = $urandom_range(1, 40);
            end
            run--;
            it.pulse = ($urandom_range(0, 9) == 0) ? pick_pulse() : hold_pulse;
         end else begin
            it.pulse = pick_pulse();
         end
         it.mv = pick_samples();
         send_item(it);
      end
   endtask

   task automatic test_reset_state();
      send_item(make_item(1500, MV_MAX, 0, 0, 0, 0));
      send_item(make_item(4095, 3400, 3399, 0, 0, 0));
      send_item(make_item(0, 0, 0, 0, 0, MV_MAX));
      send_item(make_item(0, 16384, 16383, 3399, 3399, 3399));
      send_item(make_item(4095, MV_MAX, MV_MAX, MV_MAX, MV_MAX, MV_MAX));
   endtask

   task automatic test_direct_mapping();
      apply_defaults(0);
      send_item(make_item(0, MV_MAX, 0, 0, 0, 0));
      send_item(make_item(4095, MV_MAX, 0, 0, 0, 0));
      send_item(make_item(1450, MV_MAX, 0, 0, 0, 0));
      send_item(make_item(1550, MV_MAX, 0, 0, 0, 0));
      send_item(make_item(1549, MV_MAX, 0, 0, 0, 0));
      send_item(make_item(1775, MV_MAX, 0, 0, 0, 0));
      // crossed thresholds and zero spans
      apply_settings(1600, 1400, 0, 4095, 0, 0, 32'(rcpbd_pkg::RST_CUTOFF_MV), 0);
      send_item(make_item(1500, MV_MAX, 0, 0, 0, 0));
      send_item(make_item(0, MV_MAX, 0, 0, 0, 0));
      send_item(make_item(4095, MV_MAX, 0, 0, 0, 0));
   endtask

   task automatic test_reversal_snap();
      apply_settings(1498, 1502, 1495, 1505, 4, 4, 32'(rcpbd_pkg::RST_CUTOFF_MV), 1);
      send_item(make_item(0, MV_MAX, 0, 0, 0, 0));
      send_item(make_item(4095, MV_MAX, 0, 0, 0, 0));
      send_item(make_item(4095, MV_MAX, 0, 0, 0, 0));
      send_item(make_item(4095, MV_MAX, 0, 0, 0, 0));
      send_item(make_item(0, MV_MAX, 0, 0, 0, 0));
      send_item(make_item(0, MV_MAX, 0, 0, 0, 0));
      send_item(make_item(4095, MV_MAX, 0, 0, 0, 0));
   endtask

   task automatic test_register_extremes();
      apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
      run_items(40);
      apply_settings(4095, 4095, 4095, 4095, 4095, 4095, MV_MAX, 1);
      run_items(40);
   endtask

   task automatic test_output_stall();
      random_settings(1'b0);
      @(posedge clock);
      stall_request = 400;
      run_items(40);
      settle_block();
   endtask

   task automatic test_random_mix();
      for (int p = 0; p < 13; p++) begin
         quiet = (p == 6);
         random_settings(p % 2 == 0);
         run_items((p == 6) ? 250 : 90);
      end
      quiet = 1'b0;
   endtask

   task automatic test_battery_cutoff();
      keep_battery = 1'b0;
      apply_defaults(0);
      send_item(make_item(4095, 3399, 3399, 3399, 3399, 3400));
      send_item(make_item(4095, 3399, 3400, 0, 0, 0));
      send_item(make_item(0, 3399, 3399, 3399, 3399, 3399));
      send_item(make_item(1700, MV_MAX, MV_MAX, MV_MAX, MV_MAX, MV_MAX));
      send_item(make_item(4095, 0, 0, 0, 0, 0));
   endtask

   task automatic test_random_after_dead();
      for (int p = 0; p < 4; p++) begin
         random_settings(p % 2 == 1);
         run_items(100);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_direct_mapping();
      test_reversal_snap();
      test_register_extremes();
      test_output_stall();
      test_random_mix();
      test_battery_cutoff();
      test_random_after_dead();

      settle_block();
      if (drive_mismatches == 0 && drive_results_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
